// ----- sv/csrfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Red floor detector package
// Shared widths, register indexes, filter codes and state types for the
// color sensor red floor detector.
// ----------------------------------------------------------------------------
package csrfd_pkg;

  localparam int CAPTURE_W = 32;
  localparam int REF_W     = 28;
  localparam int FREQ_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = $clog2(REF_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'b1;

  localparam logic [REF_W-1:0] REF_CLOCK_RST = REF_W'(1000000);
  localparam logic [1:0]       SCALE_RST     = 2'd1;

  localparam logic [1:0] PINS_RED   = 2'b00;
  localparam logic [1:0] PINS_GREEN = 2'b11;
  localparam logic [1:0] PINS_BLUE  = 2'b01;

  typedef enum logic [1:0] {
    FILT_RED   = 2'd0,
    FILT_GREEN = 2'd1,
    FILT_BLUE  = 2'd2
  } filter_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } div_stat_t;

  function automatic logic [1:0] pins_for(input filter_t filt);
    logic [1:0] pins;
    case (filt)
      FILT_GREEN: pins = PINS_GREEN;
      FILT_BLUE:  pins = PINS_BLUE;
      default:    pins = PINS_RED;
    endcase
    return pins;
  endfunction

endpackage
`default_nettype wire

// ----- sv/color_sensor_red_floor_detect_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Color sensor red floor detector
// Turns one period capture pair into a frequency, stores it as the level of
// the selected filter, steps the filter and flags a red floor.
// ----------------------------------------------------------------------------
// A result beat follows its input beat through a load into the divider, one
// serial divider step per dividend bit and a load into the output registers;
// a zero period skips the serial steps. The input stalls while the divider
// is busy, also while a finished result waits there on the output stall.
// Reset clears the filter to red, all levels to zero, the clock rate to
// 1000000 and the scale code to 1.
module color_sensor_red_floor_detect_core
  import csrfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REF_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CAPTURE_W-1:0] in_capture_first,
  input  wire logic [CAPTURE_W-1:0] in_capture_second,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [1:0]           out_measured_color,
  output logic      [FREQ_W-1:0]    out_frequency_value,
  output logic      [FREQ_W-1:0]    out_red_level,
  output logic      [FREQ_W-1:0]    out_green_level,
  output logic      [FREQ_W-1:0]    out_blue_level,
  output logic                      out_floor_red,
  output logic      [1:0]           out_filter_pins,
  output logic      [1:0]           out_scale_pins,
  output logic                      out_zero_period
);

  logic [REF_W-1:0]     ref_clock_r;
  logic [1:0]           scale_r;
  filter_t              filt_r, filt_nxt;
  logic [FREQ_W-1:0]    red_r, green_r, blue_r;
  logic                 out_valid_r;
  logic [1:0]           color_r;
  logic [FREQ_W-1:0]    freq_r;
  logic                 zero_r;

  logic                 in_take;
  logic                 load;
  logic [CAPTURE_W-1:0] period;
  div_stat_t            dstat;
  logic [FREQ_W-1:0]    dquot;

  logic [FREQ_W+1:0]    red2;
  logic [FREQ_W+1:0]    green3;
  logic [FREQ_W+1:0]    blue3;

  assign period  = in_capture_second - in_capture_first;
  assign in_stall = dstat.busy;
  assign in_take  = in_valid && !dstat.busy;
  assign load     = dstat.done && (!out_valid_r || !out_stall);

  csrfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_take),
    .dividend (ref_clock_r),
    .divisor  (period),
    .ack      (load),
    .stat     (dstat),
    .quotient (dquot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clock_r <= REF_CLOCK_RST;
      scale_r     <= SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_REF_CLOCK: ref_clock_r <= cfg_wdata;
        REG_SCALE:     scale_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (filt_r)
      FILT_GREEN: filt_nxt = FILT_BLUE;
      FILT_BLUE:  filt_nxt = FILT_RED;
      default:    filt_nxt = FILT_GREEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r      <= FILT_RED;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        filt_r      <= filt_nxt;
        out_valid_r <= 1'b1;
        case (filt_r)
          FILT_GREEN: green_r <= dquot;
          FILT_BLUE:  blue_r  <= dquot;
          default:    red_r   <= dquot;
        endcase
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      freq_r <= dquot;
      zero_r <= dstat.zero;
      case (filt_r)
        FILT_GREEN: color_r <= FILT_GREEN;
        FILT_BLUE:  color_r <= FILT_BLUE;
        default:    color_r <= FILT_RED;
      endcase
    end
  end

  assign red2   = {1'b0, red_r, 1'b0};
  assign green3 = {2'b00, green_r} + {1'b0, green_r, 1'b0};
  assign blue3  = {2'b00, blue_r} + {1'b0, blue_r, 1'b0};

  assign out_valid           = out_valid_r;
  assign out_measured_color  = color_r;
  assign out_frequency_value = freq_r;
  assign out_red_level       = red_r;
  assign out_green_level     = green_r;
  assign out_blue_level      = blue_r;
  assign out_floor_red       = (red2 >= green3) && (red2 >= blue3);
  assign out_filter_pins     = pins_for(filt_r);
  assign out_scale_pins      = scale_r;
  assign out_zero_period     = zero_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken but divider not busy");

  a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_period |-> out_frequency_value == '1)
    else $error("zero period without saturated frequency");

  a_red_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measured_color == FILT_RED |->
      out_frequency_value == out_red_level && out_filter_pins == PINS_GREEN)
    else $error("red beat does not match stored red level or next filter");

  a_blue_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measured_color == FILT_BLUE |->
      out_frequency_value == out_blue_level && out_filter_pins == PINS_RED)
    else $error("blue beat does not match stored blue level or next filter");

endmodule
`default_nettype wire

// ----- sv/csrfd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial frequency divider
// Restoring divider that brings in one dividend bit per cycle and keeps a
// saturating quotient of the frequency width.
// ----------------------------------------------------------------------------
module csrfd_div
  import csrfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [REF_W-1:0]     dividend,
  input  wire logic [CAPTURE_W-1:0] divisor,
  input  wire logic                 ack,
  output div_stat_t                 stat,
  output logic      [FREQ_W-1:0]    quotient
);

  div_state_t state_r, state_nxt;

  logic [CAPTURE_W-1:0] rem_r;
  logic [CAPTURE_W-1:0] dvs_r;
  logic [REF_W-1:0]     dvd_r;
  logic [FREQ_W-1:0]    q_r;
  logic                 ovf_r;
  logic                 zero_r;
  logic [CNT_W-1:0]     cnt_r;

  logic [CAPTURE_W:0]   trial;
  logic [CAPTURE_W:0]   diff;
  logic                 fits;

  assign trial = {rem_r, dvd_r[REF_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = ~diff[CAPTURE_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          state_nxt = (divisor == '0) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (ack) begin
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r != DIV_IDLE);
    stat.done = (state_r == DIV_DONE);
    stat.zero = zero_r;
    quotient  = (zero_r || ovf_r) ? '1 : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && start) begin
      rem_r  <= '0;
      dvs_r  <= divisor;
      dvd_r  <= dividend;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      zero_r <= (divisor == '0);
      cnt_r  <= CNT_W'(REF_W);
    end else if (state_r == DIV_RUN) begin
      rem_r <= fits ? diff[CAPTURE_W-1:0] : trial[CAPTURE_W-1:0];
      dvd_r <= {dvd_r[REF_W-2:0], 1'b0};
      q_r   <= {q_r[FREQ_W-2:0], fits};
      ovf_r <= ovf_r | q_r[FREQ_W-1];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- bench/floor_detect_monitor.sv -----
// ----------------------------------------------------------------------------
// Red floor detector monitor
// Watches the configuration port and both channels of the detector, predicts
// every result beat from its own copy of the filter state, stored levels and
// registers, and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module floor_detect_monitor
  import csrfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REF_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CAPTURE_W-1:0] in_capture_first,
  input  logic [CAPTURE_W-1:0] in_capture_second,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_measured_color,
  input  logic [FREQ_W-1:0]    out_frequency_value,
  input  logic [FREQ_W-1:0]    out_red_level,
  input  logic [FREQ_W-1:0]    out_green_level,
  input  logic [FREQ_W-1:0]    out_blue_level,
  input  logic                 out_floor_red,
  input  logic [1:0]           out_filter_pins,
  input  logic [1:0]           out_scale_pins,
  input  logic                 out_zero_period,
  output int                   failures,
  output int                   outstanding
);

  typedef struct packed {
    filter_t           color;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] red;
    logic [FREQ_W-1:0] green;
    logic [FREQ_W-1:0] blue;
    logic              floor;
    logic [1:0]        pins;
    logic [1:0]        scale;
    logic              zero;
  } reading_t;

  logic [REF_W-1:0]  rate;
  logic [1:0]        scale_code;
  filter_t           sel_filter;
  logic [FREQ_W-1:0] red_lvl;
  logic [FREQ_W-1:0] green_lvl;
  logic [FREQ_W-1:0] blue_lvl;
  reading_t          expected_readings[$];
  reading_t          want;

  function automatic reading_t predict_reading(input logic [CAPTURE_W-1:0] first,
                                               input logic [CAPTURE_W-1:0] second);
    logic [CAPTURE_W-1:0] period;
    logic [31:0]          quot;
    filter_t              nxt;
    reading_t             r;
    period = second - first;
    r.zero = (period == '0);
    if (r.zero) begin
      r.freq = 16'hFFFF;
    end else begin
      quot = 32'(rate) / 32'(period);
      r.freq = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
    end
    case (sel_filter)
      FILT_GREEN: begin
        green_lvl = r.freq;
        r.color = FILT_GREEN;
        nxt = FILT_BLUE;
      end
      FILT_BLUE: begin
        blue_lvl = r.freq;
        r.color = FILT_BLUE;
        nxt = FILT_RED;
      end
      default: begin
        red_lvl = r.freq;
        r.color = FILT_RED;
        nxt = FILT_GREEN;
      end
    endcase
    sel_filter = nxt;
    r.red = red_lvl;
    r.green = green_lvl;
    r.blue = blue_lvl;
    r.floor = (2 * 32'(red_lvl) >= 3 * 32'(green_lvl)) &&
              (2 * 32'(red_lvl) >= 3 * 32'(blue_lvl));
    case (nxt)
      FILT_GREEN: r.pins = PINS_GREEN;
      FILT_BLUE:  r.pins = PINS_BLUE;
      default:    r.pins = PINS_RED;
    endcase
    r.scale = scale_code;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rate = REF_CLOCK_RST;
      scale_code = SCALE_RST;
      sel_filter = FILT_RED;
      red_lvl = '0;
      green_lvl = '0;
      blue_lvl = '0;
      expected_readings.delete();
      failures = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("result beat arrived with no result expected");
          failures++;
        end else begin
          want = expected_readings.pop_front();
          check_field("measured_color", want.color, out_measured_color);
          check_field("frequency_value", want.freq, out_frequency_value);
          check_field("red_level", want.red, out_red_level);
          check_field("green_level", want.green, out_green_level);
          check_field("blue_level", want.blue, out_blue_level);
          check_field("floor_red", want.floor, out_floor_red);
          check_field("filter_pins", want.pins, out_filter_pins);
          check_field("scale_pins", want.scale, out_scale_pins);
          check_field("zero_period", want.zero, out_zero_period);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_REF_CLOCK) begin
          rate = cfg_wdata;
        end else begin
          scale_code = cfg_wdata[1:0];
        end
      end
      if (in_valid && !in_stall) begin
        expected_readings.push_back(predict_reading(in_capture_first, in_capture_second));
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Red floor detector testbench
// Drives capture pairs and register settings into the detector: a directed
// set of edge periods and ratio boundaries, then random phases with varied
// clock rates, scale codes, idle and stall patterns, and one long output
// hold-off. The monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module tb;
  import csrfd_pkg::*;

  typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_REF_CLOCK;
  logic [REF_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CAPTURE_W-1:0] in_capture_first = '0;
  logic [CAPTURE_W-1:0] in_capture_second = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_measured_color;
  logic [FREQ_W-1:0]    out_frequency_value;
  logic [FREQ_W-1:0]    out_red_level;
  logic [FREQ_W-1:0]    out_green_level;
  logic [FREQ_W-1:0]    out_blue_level;
  logic                 out_floor_red;
  logic [1:0]           out_filter_pins;
  logic [1:0]           out_scale_pins;
  logic                 out_zero_period;
  int                   failures;
  int                   outstanding;

  flow_t       flow = FLOW_FREE;
  logic        hold_go = 1'b0;
  logic        receiver_hold = 1'b0;
  int unsigned rate_now = 1000000;

  color_sensor_red_floor_detect_core dut (.*);
  floor_detect_monitor monitor (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (receiver_hold) begin
      out_stall <= 1'b1;
    end else begin
      case (flow)
        FLOW_RECV_STALL: out_stall <= ($urandom_range(99) < 86);
        FLOW_BOTH:       out_stall <= ($urandom_range(99) < 9);
        default:         out_stall <= 1'b0;
      endcase
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (300) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  function automatic bit sender_rests();
    case (flow)
      FLOW_SEND_IDLE: return $urandom_range(99) < 86;
      FLOW_BOTH:      return $urandom_range(99) < 9;
      default:        return 1'b0;
    endcase
  endfunction

  task automatic send_capture(input logic [CAPTURE_W-1:0] first,
                              input logic [CAPTURE_W-1:0] second);
    if (sender_rests()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (sender_rests());
    end
    in_valid <= 1'b1;
    in_capture_first <= first;
    in_capture_second <= second;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_regs(input logic [REF_W-1:0] rate, input logic [1:0] code);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_REF_CLOCK;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= REG_SCALE;
    cfg_wdata <= REF_W'(code);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_now = rate;
  endtask

  task automatic run_phase(input logic [REF_W-1:0] rate, input logic [1:0] code,
                           input flow_t mode, input int count, input bit hold);
    logic [CAPTURE_W-1:0] first;
    logic [CAPTURE_W-1:0] period;
    int unsigned          pick;
    settle();
    program_regs(rate, code);
    flow = mode;
    if (hold) hold_go = 1'b1;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        period = rate_now / $urandom_range(1, 70000);
        if (period == '0) period = 1;
      end else if (pick < 80) begin
        period = $urandom_range(1, 3);
      end else if (pick < 88) begin
        period = '0;
      end else begin
        period = $urandom();
      end
      first = $urandom();
      send_capture(first, first + period);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_capture(32'h0000_0000, 32'h0000_0000);
    send_capture(32'hFFFF_FFFF, 32'h0000_0000);
    send_capture(32'h0000_0000, 32'hFFFF_FFFF);
    send_capture(32'd100, 32'd115);
    send_capture(32'd7, 32'd23);
    send_capture(32'h8000_0000, 32'h8000_0000 + 32'd1000000);
    send_capture(32'h0000_0000, 32'd1000001);

    settle();
    program_regs(REF_W'(60000), 2'd0);
    send_capture(32'd10, 32'd14);
    send_capture(32'd20, 32'd26);
    send_capture(32'd30, 32'd36);
    send_capture(32'd40, 32'd45);
    send_capture(32'hAAAA_AAAA, 32'h5555_5555);
    send_capture(32'h5555_5555, 32'h5555_5558);

    settle();
    program_regs('0, 2'd2);
    send_capture(32'd1, 32'd2);
    send_capture(32'd9, 32'd9);
    send_capture(32'h1234_5678, 32'h9ABC_DEF0);

    settle();
    program_regs({REF_W{1'b1}}, 2'd3);
    send_capture(32'd50, 32'd51);
    send_capture(32'd1, 32'd0);
    send_capture(32'd0, 32'd4096);
    send_capture(32'd0, 32'd4095);

    run_phase(REF_W'(1000000), 2'd1, FLOW_FREE, 250, 1'b0);
    run_phase(REF_W'($urandom_range(1, 200000000)), 2'd2, FLOW_SEND_IDLE, 250, 1'b0);
    run_phase(REF_W'(1), 2'd0, FLOW_RECV_STALL, 150, 1'b0);
    run_phase(REF_W'(200000000), 2'd3, FLOW_BOTH, 250, 1'b0);
    run_phase(REF_W'(1000000), 2'd1, FLOW_FREE, 60, 1'b1);
    run_phase(REF_W'($urandom()), 2'($urandom_range(3)), FLOW_RECV_STALL, 250, 1'b0);
    run_phase(REF_W'(48000000), 2'd2, FLOW_FREE, 240, 1'b0);
    settle();

    if (failures == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/csrfd_pkg.sv
sv/csrfd_div.sv
sv/color_sensor_red_floor_detect_core.sv
bench/floor_detect_monitor.sv
bench/tb.sv
